// ===== rtl/dsu_pkg.sv =====
// ----------------------------------------------------------------------------
// dsu_pkg
// Shared widths and types of the disjoint-set union-find engine.
// ----------------------------------------------------------------------------
package dsu_pkg;

    localparam int NODES       = 1024;
    localparam int NODE_W      = $clog2(NODES);
    localparam int SIZE_W      = 11;
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 32;

    localparam logic [SIZE_W-1:0] SIZE_MAX = {SIZE_W{1'b1}};

    typedef enum logic {
        FUNC_FIND  = 1'b0,
        FUNC_UNION = 1'b1
    } t_func;

    typedef struct packed {
        t_func             func;
        logic [NODE_W-1:0] node_a;
        logic [NODE_W-1:0] node_b;
    } t_req;

    typedef struct packed {
        logic [NODE_W-1:0] root_a;
        logic [NODE_W-1:0] root_b;
        logic              already_joined;
        logic [NODE_W-1:0] new_root;
    } t_result;

    typedef struct packed {
        logic              en;
        logic [NODE_W-1:0] addr;
        logic [NODE_W-1:0] data;
    } t_par_wr;

    typedef struct packed {
        logic              en;
        logic [NODE_W-1:0] addr;
        logic [SIZE_W-1:0] data;
    } t_size_wr;

endpackage

// ===== rtl/dsu_ram.sv =====
// ----------------------------------------------------------------------------
// dsu_ram
// Simple dual-port RAM, one write and one registered read port, read-first.
// ----------------------------------------------------------------------------
module dsu_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 10
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/dsu_ctrl.sv =====
// ----------------------------------------------------------------------------
// dsu_ctrl
// Sequencer: clearing pass, root walk, path compression and size merge.
// ----------------------------------------------------------------------------
module dsu_ctrl
    import dsu_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_req_valid,
    output logic              o_req_ready,
    input  t_req              i_req,
    output logic [NODE_W-1:0] o_par_raddr,
    input  logic [NODE_W-1:0] i_par_rdata,
    output t_par_wr           o_par_wr,
    output logic [NODE_W-1:0] o_size_raddr,
    input  logic [SIZE_W-1:0] i_size_rdata,
    output t_size_wr          o_size_wr,
    output logic              o_res_valid,
    input  logic              i_res_ready,
    output t_result           o_res
);

    typedef enum logic [8:0] {
        S_CLEAR = 9'b000000001,
        S_IDLE  = 9'b000000010,
        S_RD    = 9'b000000100,
        S_WALK  = 9'b000001000,
        S_CMP   = 9'b000010000,
        S_SZA   = 9'b000100000,
        S_SZB   = 9'b001000000,
        S_SZC   = 9'b010000000,
        S_DONE  = 9'b100000000
    } t_state;

    t_state            r_state, n_state;
    logic [NODE_W-1:0] r_clr, n_clr;
    logic              r_phase_b, n_phase_b;
    t_func             r_func, n_func;
    logic [NODE_W-1:0] r_b, n_b;
    logic [NODE_W-1:0] r_cur, n_cur;
    logic [NODE_W-1:0] r_start, n_start;
    logic [NODE_W-1:0] r_root, n_root;
    logic [NODE_W-1:0] r_ra, n_ra;
    logic [NODE_W-1:0] r_rb, n_rb;
    logic [NODE_W-1:0] r_nr, n_nr;
    logic              r_joined, n_joined;
    logic [SIZE_W-1:0] r_sza, n_sza;

    logic              w_find_done;
    logic [NODE_W-1:0] w_found;
    logic [SIZE_W:0]   w_sum;
    logic [SIZE_W-1:0] w_sum_sat;

    assign w_sum     = {1'b0, r_sza} + {1'b0, i_size_rdata};
    assign w_sum_sat = w_sum[SIZE_W] ? SIZE_MAX : w_sum[SIZE_W-1:0];

    always_comb begin
        n_state      = r_state;
        n_clr        = r_clr;
        n_phase_b    = r_phase_b;
        n_func       = r_func;
        n_b          = r_b;
        n_cur        = r_cur;
        n_start      = r_start;
        n_root       = r_root;
        n_ra         = r_ra;
        n_rb         = r_rb;
        n_nr         = r_nr;
        n_joined     = r_joined;
        n_sza        = r_sza;
        w_find_done  = 1'b0;
        w_found      = r_cur;
        o_par_raddr  = r_cur;
        o_size_raddr = r_ra;
        o_par_wr     = '0;
        o_size_wr    = '0;

        unique case (r_state)
            S_CLEAR: begin
                o_par_wr  = '{en: 1'b1, addr: r_clr, data: r_clr};
                o_size_wr = '{en: 1'b1, addr: r_clr, data: SIZE_W'(1)};
                n_clr     = r_clr + NODE_W'(1);
                if (r_clr == NODE_W'(NODES - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_req_valid) begin
                    n_func    = i_req.func;
                    n_b       = i_req.node_b;
                    n_cur     = i_req.node_a;
                    n_start   = i_req.node_a;
                    n_phase_b = 1'b0;
                    n_state   = S_RD;
                end
            end
            S_RD: begin
                n_state = S_WALK;
            end
            S_WALK: begin
                // read data is the parent of r_cur
                if (i_par_rdata == r_cur) begin
                    n_root = r_cur;
                    if (r_start == r_cur) begin
                        w_find_done = 1'b1;
                        w_found     = r_cur;
                    end else begin
                        o_par_raddr = r_start;
                        n_cur       = r_start;
                        n_state     = S_CMP;
                    end
                end else begin
                    o_par_raddr = i_par_rdata;
                    n_cur       = i_par_rdata;
                end
            end
            S_CMP: begin
                // repoint r_cur to the root, then follow its old parent
                o_par_wr = '{en: 1'b1, addr: r_cur, data: r_root};
                if (i_par_rdata == r_root) begin
                    w_find_done = 1'b1;
                    w_found     = r_root;
                end else begin
                    o_par_raddr = i_par_rdata;
                    n_cur       = i_par_rdata;
                end
            end
            S_SZA: begin
                o_size_raddr = r_ra;
                n_state      = S_SZB;
            end
            S_SZB: begin
                o_size_raddr = r_rb;
                n_sza        = i_size_rdata;
                n_state      = S_SZC;
            end
            S_SZC: begin
                if (r_sza > i_size_rdata) begin
                    o_par_wr  = '{en: 1'b1, addr: r_rb, data: r_ra};
                    o_size_wr = '{en: 1'b1, addr: r_ra, data: w_sum_sat};
                    n_nr      = r_ra;
                end else begin
                    o_par_wr  = '{en: 1'b1, addr: r_ra, data: r_rb};
                    o_size_wr = '{en: 1'b1, addr: r_rb, data: w_sum_sat};
                    n_nr      = r_rb;
                end
                n_joined = 1'b0;
                n_state  = S_DONE;
            end
            S_DONE: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (w_find_done) begin
            if (!r_phase_b) begin
                n_ra = w_found;
                if (r_func == FUNC_FIND) begin
                    n_rb     = w_found;
                    n_nr     = w_found;
                    n_joined = 1'b0;
                    n_state  = S_DONE;
                end else begin
                    n_phase_b = 1'b1;
                    n_cur     = r_b;
                    n_start   = r_b;
                    n_state   = S_RD;
                end
            end else begin
                n_rb = w_found;
                if (w_found == r_ra) begin
                    n_joined = 1'b1;
                    n_nr     = r_ra;
                    n_state  = S_DONE;
                end else begin
                    n_state = S_SZA;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_clr     <= '0;
            r_phase_b <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_clr     <= n_clr;
            r_phase_b <= n_phase_b;
        end
    end

    always_ff @(posedge i_clk) begin
        r_func   <= n_func;
        r_b      <= n_b;
        r_cur    <= n_cur;
        r_start  <= n_start;
        r_root   <= n_root;
        r_ra     <= n_ra;
        r_rb     <= n_rb;
        r_nr     <= n_nr;
        r_joined <= n_joined;
        r_sza    <= n_sza;
    end

    assign o_req_ready          = (r_state == S_IDLE);
    assign o_res_valid          = (r_state == S_DONE);
    assign o_res.root_a         = r_ra;
    assign o_res.root_b         = r_rb;
    assign o_res.already_joined = r_joined;
    assign o_res.new_root       = r_nr;

endmodule

// ===== rtl/disjoint_set_union_find_core.sv =====
// ----------------------------------------------------------------------------
// disjoint_set_union_find_core
// Union-find engine with path compression and union by size.
// ----------------------------------------------------------------------------
//  channel  dir  fields (low bit up)
//  s_axis   in   tdata: node_a[9:0], node_b[19:10], zero pad; tuser: func
//  m_axis   out  tdata: root_a[9:0], root_b[19:10], new_root[29:20], pad;
//                tuser: already_joined
//
//  a find walks the parent links from its node to the root, then walks the path
//  again to compress it when the start node is not the root
//  a union does the same for node_a and then for node_b, and merges the sizes
//  when the roots differ; each parent link costs one RAM read
//  after reset a clearing pass writes all 1024 nodes of both RAMs; no beat is taken
//  one request is worked at a time; a finished result waits in the output
//  register while the next request is accepted
// ----------------------------------------------------------------------------
module disjoint_set_union_find_core
    import dsu_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  i_s_axis_tdata,  // node_a, node_b
    input  logic                   i_s_axis_tuser,  // func
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    output logic [OUT_TDATA_W-1:0] o_m_axis_tdata,  // root_a, root_b, new_root
    output logic                   o_m_axis_tuser   // already_joined
);

    t_req              w_req;
    t_result           w_res;
    logic              w_res_valid;
    logic              w_res_ready;
    logic [NODE_W-1:0] w_par_raddr;
    logic [NODE_W-1:0] w_par_rdata;
    t_par_wr           w_par_wr;
    logic [NODE_W-1:0] w_size_raddr;
    logic [SIZE_W-1:0] w_size_rdata;
    t_size_wr          w_size_wr;

    logic              r_out_valid;
    t_result           r_out;

    assign w_req.func   = t_func'(i_s_axis_tuser);
    assign w_req.node_a = i_s_axis_tdata[NODE_W-1:0];
    assign w_req.node_b = i_s_axis_tdata[2*NODE_W-1:NODE_W];

    dsu_ram #(.DEPTH(NODES), .WIDTH(NODE_W)) u_parent_ram (
        .i_clk   (i_clk),
        .i_we    (w_par_wr.en),
        .i_waddr (w_par_wr.addr),
        .i_wdata (w_par_wr.data),
        .i_raddr (w_par_raddr),
        .o_rdata (w_par_rdata)
    );

    dsu_ram #(.DEPTH(NODES), .WIDTH(SIZE_W)) u_size_ram (
        .i_clk   (i_clk),
        .i_we    (w_size_wr.en),
        .i_waddr (w_size_wr.addr),
        .i_wdata (w_size_wr.data),
        .i_raddr (w_size_raddr),
        .o_rdata (w_size_rdata)
    );

    dsu_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_valid  (i_s_axis_tvalid),
        .o_req_ready  (o_s_axis_tready),
        .i_req        (w_req),
        .o_par_raddr  (w_par_raddr),
        .i_par_rdata  (w_par_rdata),
        .o_par_wr     (w_par_wr),
        .o_size_raddr (w_size_raddr),
        .i_size_rdata (w_size_rdata),
        .o_size_wr    (w_size_wr),
        .o_res_valid  (w_res_valid),
        .i_res_ready  (w_res_ready),
        .o_res        (w_res)
    );

    // output register frees the sequencer while a beat waits
    assign w_res_ready = !r_out_valid || i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_valid && w_res_ready) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_valid && w_res_ready) begin
            r_out <= w_res;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_out.already_joined;
    assign o_m_axis_tdata  = {
        (OUT_TDATA_W - 3*NODE_W)'(0), r_out.new_root, r_out.root_b, r_out.root_a
    };

    a_joined_same_root: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser |->
            o_m_axis_tdata[NODE_W-1:0] == o_m_axis_tdata[2*NODE_W-1:NODE_W])
        else $error("joined result with differing roots");

    a_new_root_is_a_root: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |->
            o_m_axis_tdata[3*NODE_W-1:2*NODE_W] == o_m_axis_tdata[NODE_W-1:0] ||
            o_m_axis_tdata[3*NODE_W-1:2*NODE_W] == o_m_axis_tdata[2*NODE_W-1:NODE_W])
        else $error("new root is neither input root");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> !o_s_axis_tready)
        else $error("second request taken while one is in flight");

    a_no_write_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_axis_tready |-> !w_par_wr.en && !w_size_wr.en)
        else $error("memory written while idle");

endmodule
